FILE: hw/rtl/ezr_pkg.sv
package ezr_pkg;

	// Internal angle and sum width; Q30 values up to plus or minus 4.0 need 34 bits.
	localparam int QW = 36;
	// Multiplier operand width; sines and cosines stay near plus or minus 1.0 in Q30.
	localparam int MW = 34;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);

	localparam logic signed [QW-1:0] Q30_PI      = QW'(64'sd3373259426);
	localparam logic signed [QW-1:0] Q30_HALF_PI = QW'(64'sd1686629713);
	localparam logic signed [QW-1:0] Q30_TWO_PI  = QW'(64'sd6746518852);
	localparam logic signed [QW-1:0] Q30_GAIN    = QW'(64'sd652032874);

	typedef struct packed {
		logic signed [QW-1:0] z;
		logic                 negc;
	} ezr_angle_t;

	typedef struct packed {
		ezr_angle_t roll;
		ezr_angle_t pitch;
		ezr_angle_t yaw;
	} ezr_item_t;

	function automatic logic signed [QW-1:0] atan_q30(input int i);
		logic signed [QW-1:0] r;
		case (i)
			0:  r = QW'(64'sd843314857);
			1:  r = QW'(64'sd497837829);
			2:  r = QW'(64'sd263043837);
			3:  r = QW'(64'sd133525159);
			4:  r = QW'(64'sd67021687);
			5:  r = QW'(64'sd33543516);
			6:  r = QW'(64'sd16775851);
			7:  r = QW'(64'sd8388437);
			8:  r = QW'(64'sd4194283);
			9:  r = QW'(64'sd2097149);
			default: r = (i < 30) ? (QW'(1) <<< (30 - i)) : '0;
		endcase
		return r;
	endfunction

	// Q30 product rounded back to Q30, half up, floor shift.
	function automatic logic signed [MW-1:0] mulq(input logic signed [MW-1:0] a,
			input logic signed [MW-1:0] b);
		logic signed [2*MW-1:0] p;
		p = a * b;
		p = p + (2*MW)'(64'sd536870912);
		p = p >>> 30;
		return p[MW-1:0];
	endfunction

endpackage

FILE: hw/rtl/ezr_ifs.sv
interface ezr_angle_if #(parameter int ANGLE_BITS = 16);
	logic valid;
	logic ready;
	logic signed [ANGLE_BITS-1:0] roll_angle;
	logic signed [ANGLE_BITS-1:0] pitch_angle;
	logic signed [ANGLE_BITS-1:0] yaw_angle;
	modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
	modport sink (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

interface ezr_matrix_if #(parameter int ELEMENT_BITS = 16);
	logic valid;
	logic ready;
	logic signed [ELEMENT_BITS-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		input ready);
	modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		output ready);
endinterface

FILE: hw/rtl/ezr_front.sv
module ezr_front import ezr_pkg::*; #(
	parameter int ANGLE_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	ezr_angle_if.sink in_ch,
	input  logic      q_full,
	output logic      q_push,
	output ezr_item_t q_item
);
	logic      valid_q;
	ezr_item_t item_q;
	ezr_item_t item_d;

	// Scale to Q30, wrap into [-pi, pi], then fold into [-pi/2, pi/2].
	function automatic ezr_angle_t reduce(input logic signed [ANGLE_BITS-1:0] raw);
		logic signed [QW-1:0] a;
		ezr_angle_t r;
		a = QW'(raw) <<< (33 - ANGLE_BITS);
		if (a > Q30_PI) begin
			a = a - Q30_TWO_PI;
		end else if (a < -Q30_PI) begin
			a = a + Q30_TWO_PI;
		end
		r.negc = 1'b0;
		if (a > Q30_HALF_PI) begin
			a = Q30_PI - a;
			r.negc = 1'b1;
		end else if (a < -Q30_HALF_PI) begin
			a = -Q30_PI - a;
			r.negc = 1'b1;
		end
		r.z = a;
		return r;
	endfunction

	always_comb begin
		item_d.roll  = reduce(in_ch.roll_angle);
		item_d.pitch = reduce(in_ch.pitch_angle);
		item_d.yaw   = reduce(in_ch.yaw_angle);
	end

	assign q_push = valid_q && !q_full;
	assign in_ch.ready = !valid_q || !q_full;
	assign q_item = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ch.ready) begin
			valid_q <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_q <= item_d;
		end
	end
endmodule

FILE: hw/rtl/ezr_fifo.sv
module ezr_fifo import ezr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  ezr_item_t push_item,
	output logic      full,
	input  logic      pop,
	output logic      empty,
	output ezr_item_t head
);
	ezr_item_t                entries_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]       wr_q;
	logic [FIFO_AW-1:0]       rd_q;
	logic [FIFO_AW:0]         cnt_q;

	assign full  = cnt_q == (FIFO_AW+1)'(FIFO_DEPTH);
	assign empty = cnt_q == '0;
	assign head  = entries_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_q] <= push_item;
		end
	end
endmodule

FILE: hw/rtl/ezr_cordic.sv
module ezr_cordic import ezr_pkg::*; #(
	parameter int ITER = 16
) (
	input  logic                 clk,
	input  logic                 en,
	input  ezr_angle_t           ang,
	output logic signed [MW-1:0] s,
	output logic signed [MW-1:0] c
);
	logic signed [QW-1:0] x_s [ITER+1];
	logic signed [QW-1:0] y_s [ITER+1];
	logic signed [QW-1:0] z_s [ITER+1];
	logic                 negc_s [ITER+1];

	assign x_s[0]    = Q30_GAIN;
	assign y_s[0]    = '0;
	assign z_s[0]    = ang.z;
	assign negc_s[0] = ang.negc;

	for (genvar i = 0; i < ITER; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				negc_s[i+1] <= negc_s[i];
				if (!z_s[i][QW-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_q30(i);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_q30(i);
				end
			end
		end
	end

	assign s = y_s[ITER][MW-1:0];
	assign c = negc_s[ITER] ? -x_s[ITER][MW-1:0] : x_s[ITER][MW-1:0];
endmodule

FILE: hw/rtl/ezr_back.sv
module ezr_back import ezr_pkg::*; #(
	parameter int ELEMENT_BITS = 16,
	parameter int SINCOS_ITERATIONS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  ezr_item_t      q_head,
	output logic           q_pop,
	ezr_matrix_if.source   out_ch
);
	localparam int LAT = SINCOS_ITERATIONS + 3;
	localparam int SH = 32 - ELEMENT_BITS;
	localparam int RND_SH = (SH > 0) ? SH - 1 : 0;
	localparam logic signed [QW-1:0] RND = (SH > 0) ? (QW'(1) <<< RND_SH) : '0;
	localparam logic signed [QW-1:0] LIM = QW'(1) <<< (ELEMENT_BITS - 2);

	logic en;
	logic [LAT-1:0] vld_q;
	logic signed [MW-1:0] sa, ca, sb, cb, sg, cg;

	logic signed [MW-1:0] sbsa_s1, sbca_s1, cgcb_s1, sgca_s1, sgsa_s1, sgcb_s1;
	logic signed [MW-1:0] cgca_s1, cgsa_s1, cbsa_s1, cbca_s1, sb_s1, sg_s1, cg_s1;
	logic signed [MW-1:0] cgsbsa_s2, sgsbsa_s2, cgsbca_s2, sgsbca_s2;
	logic signed [MW-1:0] cgcb_s2, sgca_s2, sgsa_s2, sgcb_s2, cgca_s2, cgsa_s2;
	logic signed [MW-1:0] cbsa_s2, cbca_s2, sb_s2;
	logic signed [ELEMENT_BITS-1:0] el_d [9];
	logic signed [QW-1:0] sum [9];

	function automatic logic signed [ELEMENT_BITS-1:0] to_el(input logic signed [QW-1:0] v);
		logic signed [QW-1:0] r;
		r = (v + RND) >>> SH;
		if (r > LIM) begin
			r = LIM;
		end else if (r < -LIM) begin
			r = -LIM;
		end
		return r[ELEMENT_BITS-1:0];
	endfunction

	assign en = !out_ch.valid || out_ch.ready;
	assign q_pop = en && !q_empty;
	assign out_ch.valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], !q_empty};
		end
	end

	ezr_cordic #(.ITER(SINCOS_ITERATIONS)) u_roll (
		.clk(clk), .en(en), .ang(q_head.roll), .s(sa), .c(ca));
	ezr_cordic #(.ITER(SINCOS_ITERATIONS)) u_pitch (
		.clk(clk), .en(en), .ang(q_head.pitch), .s(sb), .c(cb));
	ezr_cordic #(.ITER(SINCOS_ITERATIONS)) u_yaw (
		.clk(clk), .en(en), .ang(q_head.yaw), .s(sg), .c(cg));

	always_ff @(posedge clk) begin
		if (en) begin
			sbsa_s1 <= mulq(sb, sa);
			sbca_s1 <= mulq(sb, ca);
			cgcb_s1 <= mulq(cg, cb);
			sgca_s1 <= mulq(sg, ca);
			sgsa_s1 <= mulq(sg, sa);
			sgcb_s1 <= mulq(sg, cb);
			cgca_s1 <= mulq(cg, ca);
			cgsa_s1 <= mulq(cg, sa);
			cbsa_s1 <= mulq(cb, sa);
			cbca_s1 <= mulq(cb, ca);
			sb_s1   <= sb;
			sg_s1   <= sg;
			cg_s1   <= cg;

			cgsbsa_s2 <= mulq(cg_s1, sbsa_s1);
			sgsbsa_s2 <= mulq(sg_s1, sbsa_s1);
			cgsbca_s2 <= mulq(cg_s1, sbca_s1);
			sgsbca_s2 <= mulq(sg_s1, sbca_s1);
			cgcb_s2 <= cgcb_s1;
			sgca_s2 <= sgca_s1;
			sgsa_s2 <= sgsa_s1;
			sgcb_s2 <= sgcb_s1;
			cgca_s2 <= cgca_s1;
			cgsa_s2 <= cgsa_s1;
			cbsa_s2 <= cbsa_s1;
			cbca_s2 <= cbca_s1;
			sb_s2   <= sb_s1;
		end
	end

	always_comb begin
		sum[0] = QW'(cgcb_s2);
		sum[1] = QW'(cgsbsa_s2) - QW'(sgca_s2);
		sum[2] = QW'(cgsbca_s2) + QW'(sgsa_s2);
		sum[3] = QW'(sgcb_s2);
		sum[4] = QW'(sgsbsa_s2) + QW'(cgca_s2);
		sum[5] = QW'(sgsbca_s2) - QW'(cgsa_s2);
		sum[6] = -QW'(sb_s2);
		sum[7] = QW'(cbsa_s2);
		sum[8] = QW'(cbca_s2);
		for (int k = 0; k < 9; k++) begin
			el_d[k] = to_el(sum[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_ch.m00 <= el_d[0];
			out_ch.m01 <= el_d[1];
			out_ch.m02 <= el_d[2];
			out_ch.m10 <= el_d[3];
			out_ch.m11 <= el_d[4];
			out_ch.m12 <= el_d[5];
			out_ch.m20 <= el_d[6];
			out_ch.m21 <= el_d[7];
			out_ch.m22 <= el_d[8];
		end
	end
endmodule

FILE: hw/rtl/euler_zyx_to_rotation_matrix.sv
// Converts ZYX Euler angles (roll, pitch, yaw in signed Q3.(ANGLE_BITS-3) radians) into the
// nine elements of Rz(yaw)*Ry(pitch)*Rx(roll), each signed Q2.(ELEMENT_BITS-2), rounded and
// saturated to plus or minus 1.0; angles beyond plus or minus pi wrap by 2*pi. One item is
// accepted per cycle while the queue is not full, and each passes through the input
// stage, the four-entry queue, one register per step of the pipelined CORDIC sine/cosine
// units, two multiplier stages and the output register. The queue lets the input keep
// taking items while the output is held, until the queue is full.
module euler_zyx_to_rotation_matrix import ezr_pkg::*; #(
	parameter int ANGLE_BITS = 16,
	parameter int ELEMENT_BITS = 16,
	parameter int SINCOS_ITERATIONS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	ezr_angle_if.sink    in_ch,
	ezr_matrix_if.source out_ch
);
	logic      q_full;
	logic      q_push;
	logic      q_pop;
	logic      q_empty;
	ezr_item_t q_item;
	ezr_item_t q_head;

	ezr_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.q_full(q_full), .q_push(q_push), .q_item(q_item));

	ezr_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(q_push), .push_item(q_item), .full(q_full),
		.pop(q_pop), .empty(q_empty), .head(q_head));

	ezr_back #(.ELEMENT_BITS(ELEMENT_BITS), .SINCOS_ITERATIONS(SINCOS_ITERATIONS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(q_empty), .q_head(q_head), .q_pop(q_pop),
		.out_ch(out_ch));
endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
	import ezr_pkg::*;

	localparam int AB = 16;
	localparam int EB = 16;
	localparam int ITERS = 16;
	localparam int LATENCY = ITERS + 5;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_ITEMS = 1900;
	localparam int DIRECTED_ITEMS = 20;
	localparam logic signed [15:0] ANG_MAX = 16'sd25736;
	localparam logic signed [15:0] ONE = 16'sd16384;

	typedef logic signed [EB-1:0] elem_t;
	typedef logic signed [AB-1:0] angle_t;
	typedef struct {
		elem_t m[9];
	} matrix_t;
	typedef struct {
		logic signed [AB-1:0] roll, pitch, yaw;
		bit known;
		elem_t m[9];
	} pose_row_t;

	logic clk;
	logic arst_n;

	ezr_angle_if #(.ANGLE_BITS(AB)) in_ch ();
	ezr_matrix_if #(.ELEMENT_BITS(EB)) out_ch ();

	euler_zyx_to_rotation_matrix #(
		.ANGLE_BITS(AB),
		.ELEMENT_BITS(EB),
		.SINCOS_ITERATIONS(ITERS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	matrix_t pending_matrices[$];
	pose_row_t pose_table[DIRECTED_ITEMS];
	int errors = 0;
	int idle_cycles = 0;
	bit long_hold = 0;
	bit stim_done = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint q30_mul(longint a, longint b);
		return floor_shift(a * b + (64'sd1 <<< 29), 30);
	endfunction

	function automatic longint atan_step(int i);
		longint t[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
			33543516, 16775851, 8388437, 4194283, 2097149};
		if (i < 10)
			return t[i];
		return 64'sd1 <<< (30 - i);
	endfunction

	task automatic angle_sincos(input logic signed [AB-1:0] raw, output longint s,
			output longint c);
		longint a, x, y, z, dx, dy;
		bit flip;
		a = longint'(raw) * (64'sd1 <<< (33 - AB));
		flip = 0;
		x = 652032874;
		y = 0;
		if (a > 64'sd3373259426)
			a -= 64'sd6746518852;
		else if (a < -64'sd3373259426)
			a += 64'sd6746518852;
		if (a > 64'sd1686629713) begin
			a = 64'sd3373259426 - a;
			flip = 1;
		end else if (a < -64'sd1686629713) begin
			a = -64'sd3373259426 - a;
			flip = 1;
		end
		z = a;
		for (int i = 0; i < ITERS && i < 30; i++) begin
			dx = floor_shift(y, i);
			dy = floor_shift(x, i);
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= atan_step(i);
			end else begin
				x += dx;
				y -= dy;
				z += atan_step(i);
			end
		end
		s = y;
		c = flip ? -x : x;
	endtask

	function automatic elem_t q30_to_element(longint v);
		longint r;
		longint lim;
		lim = 64'sd1 <<< (EB - 2);
		r = floor_shift(v + (64'sd1 <<< (31 - EB)), 32 - EB);
		if (r > lim)
			r = lim;
		if (r < -lim)
			r = -lim;
		return elem_t'(r);
	endfunction

	task automatic rotation_of(input logic signed [AB-1:0] roll, pitch, yaw,
			output matrix_t mat);
		longint sa, ca, sb, cb, sg, cg, sbsa, sbca;
		angle_sincos(roll, sa, ca);
		angle_sincos(pitch, sb, cb);
		angle_sincos(yaw, sg, cg);
		sbsa = q30_mul(sb, sa);
		sbca = q30_mul(sb, ca);
		mat.m[0] = q30_to_element(q30_mul(cg, cb));
		mat.m[1] = q30_to_element(q30_mul(cg, sbsa) - q30_mul(sg, ca));
		mat.m[2] = q30_to_element(q30_mul(cg, sbca) + q30_mul(sg, sa));
		mat.m[3] = q30_to_element(q30_mul(sg, cb));
		mat.m[4] = q30_to_element(q30_mul(sg, sbsa) + q30_mul(cg, ca));
		mat.m[5] = q30_to_element(q30_mul(sg, sbca) - q30_mul(cg, sa));
		mat.m[6] = q30_to_element(-sb);
		mat.m[7] = q30_to_element(q30_mul(cb, sa));
		mat.m[8] = q30_to_element(q30_mul(cb, ca));
	endtask

	function automatic pose_row_t row(logic signed [AB-1:0] r, p, y, bit known,
			elem_t e0 = 0, elem_t e4 = 0, elem_t e8 = 0);
		pose_row_t t;
		t.roll = r;
		t.pitch = p;
		t.yaw = y;
		t.known = known;
		foreach (t.m[i])
			t.m[i] = '0;
		t.m[0] = e0;
		t.m[4] = e4;
		t.m[8] = e8;
		return t;
	endfunction

	initial begin
		// Zero angles give the identity; the rest exercise extremes, wrapping and folding.
		pose_table[0] = row(0, 0, 0, 1, ONE, ONE, ONE);
		pose_table[1] = row(ANG_MAX, 0, 0, 0);
		pose_table[2] = row(-ANG_MAX, 0, 0, 0);
		pose_table[3] = row(0, ANG_MAX, 0, 0);
		pose_table[4] = row(0, -ANG_MAX, 0, 0);
		pose_table[5] = row(0, 0, ANG_MAX, 0);
		pose_table[6] = row(0, 0, -ANG_MAX, 0);
		pose_table[7] = row(16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
		pose_table[8] = row(16'sh8000, 16'sh8000, 16'sh8000, 0);
		pose_table[9] = row(12868, 12868, 12868, 0);
		pose_table[10] = row(-12868, -12868, -12868, 0);
		pose_table[11] = row(12869, -12869, 12867, 0);
		pose_table[12] = row(25737, -25737, 25800, 0);
		pose_table[13] = row(6434, -6434, 19302, 0);
		pose_table[14] = row(1, -1, 1, 0);
		pose_table[15] = row(16'sh5555, 16'shaaaa, 16'sh5555, 0);
		pose_table[16] = row(16'shaaaa, 16'sh5555, 16'shaaaa, 0);
		pose_table[17] = row(-1, -1, -1, 0);
		pose_table[18] = row(8578, 17157, -4289, 0);
		pose_table[19] = row(32000, -32000, 30000, 0);
	end

	task automatic send_pose(input logic signed [AB-1:0] r, p, y);
		matrix_t mat;
		in_ch.valid <= 1;
		in_ch.roll_angle <= r;
		in_ch.pitch_angle <= p;
		in_ch.yaw_angle <= y;
		do
			@(posedge clk);
		while (!in_ch.ready);
		rotation_of(r, p, y, mat);
		pending_matrices = {pending_matrices, mat};
	endtask

	task automatic sender_gap();
		int gap;
		gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
		if (gap > 0) begin
			in_ch.valid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic signed [AB-1:0] rand_angle();
		case ($urandom_range(0, 9))
			0: return angle_t'($urandom);
			1: return $urandom_range(0, 1) ? ANG_MAX : -ANG_MAX;
			default: return angle_t'(int'($urandom_range(0, 2 * 25736)) - 25736);
		endcase
	endfunction

	initial begin
		int burst;
		arst_n = 0;
		in_ch.valid = 0;
		in_ch.roll_angle = 0;
		in_ch.pitch_angle = 0;
		in_ch.yaw_angle = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		for (int i = 0; i < DIRECTED_ITEMS; i++) begin
			if (pose_table[i].known) begin
				matrix_t mat;
				rotation_of(pose_table[i].roll, pose_table[i].pitch, pose_table[i].yaw, mat);
				for (int k = 0; k < 9; k += 4)
					if (mat.m[k] != pose_table[i].m[k]) begin
						$error("m%0d%0d expected %0d got %0d", k / 3, k % 3,
							pose_table[i].m[k], mat.m[k]);
						errors++;
					end
			end
			send_pose(pose_table[i].roll, pose_table[i].pitch, pose_table[i].yaw);
			sender_gap();
		end
		// Drain completely before the random part.
		in_ch.valid <= 0;
		while (pending_matrices.size() != 0)
			@(posedge clk);
		long_hold = 1;
		for (int n = 0; n < RANDOM_ITEMS; ) begin
			burst = $urandom_range(1, 40);
			for (int b = 0; b < burst && n < RANDOM_ITEMS; b++, n++)
				send_pose(rand_angle(), rand_angle(), rand_angle());
			sender_gap();
		end
		in_ch.valid <= 0;
		stim_done = 1;
	end

	initial begin
		int phase;
		out_ch.ready = 0;
		phase = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				long_hold = 0;
				out_ch.ready <= 0;
				repeat (60) @(posedge clk);
			end
			phase++;
			// Stall pattern: quiet windows alternate with random stalls.
			if ((phase / 200) % 2 == 0)
				out_ch.ready <= 1;
			else
				out_ch.ready <= ($urandom_range(0, 3) != 0);
		end
	end

	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready) begin
			matrix_t exp_m, got;
			got.m = '{out_ch.m00, out_ch.m01, out_ch.m02, out_ch.m10, out_ch.m11,
				out_ch.m12, out_ch.m20, out_ch.m21, out_ch.m22};
			if (pending_matrices.size() == 0) begin
				$error("matrix item with no pending expectation");
				errors++;
			end else begin
				exp_m = pending_matrices.pop_front();
				foreach (got.m[i])
					if (got.m[i] !== exp_m.m[i]) begin
						$error("m%0d%0d expected %0d got %0d", i / 3, i % 3, exp_m.m[i],
							got.m[i]);
						errors++;
					end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		@(posedge arst_n);
		fork
			begin
				wait (stim_done);
				while (pending_matrices.size() != 0)
					@(posedge clk);
				repeat (LATENCY * 2) @(posedge clk);
			end
			wait (idle_cycles >= WATCHDOG_LIMIT);
		join_any
		if (idle_cycles >= WATCHDOG_LIMIT)
			errors++;
		if (errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

FILE: euler_zyx_to_rotation_matrix.f
hw/rtl/ezr_pkg.sv
hw/rtl/ezr_ifs.sv
hw/rtl/ezr_front.sv
hw/rtl/ezr_fifo.sv
hw/rtl/ezr_cordic.sv
hw/rtl/ezr_back.sv
hw/rtl/euler_zyx_to_rotation_matrix.sv
tb/sv/tb.sv
